[hw/rtl/swc_pkg.sv]
// shared constants, codes and types of the sliding window convolution block
package swc_pkg;

   localparam int MAX_KERNEL = 5;
   localparam int MAX_WIDTH  = 1024;

   localparam int KMAX_ODD   = (MAX_KERNEL - 1) | 1;
   localparam int HALF_MAX   = KMAX_ODD / 2;
   localparam int COEF_SLOTS = MAX_KERNEL * MAX_KERNEL;
   localparam int LINE_ROWS  = MAX_KERNEL - 1;

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int IMG_W_W    = 11;
   localparam int ROW_W      = 12;
   localparam int KDIM_W     = 3;
   localparam int PIX_W      = 8;
   localparam int COEF_W     = 16;
   localparam int CIDX_W     = 5;
   localparam int CONV_W     = 32;
   localparam int WORD_W     = LINE_ROWS * PIX_W;

   localparam int PROD_W     = PIX_W + COEF_W + 1;
   localparam int RSUM_W     = PROD_W + $clog2(MAX_KERNEL);
   localparam int TSUM_W     = RSUM_W + $clog2(MAX_KERNEL);

   localparam int RSP_DEPTH  = 8;
   localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W  = RSP_PTR_W + 1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = IMG_W_W'(640);
   localparam logic [ROW_W-1:0]   IMAGE_HEIGHT_RST = ROW_W'(480);
   localparam logic [KDIM_W-1:0]  KERNEL_DIM_RST   = KDIM_W'(3);

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_COEF  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_KERNEL_WIDTH  = 2'd2,
      CSR_KERNEL_HEIGHT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
      logic [PIX_W-1:0] pixel;
   } lb_req_type;

   typedef struct packed {
      logic                     out_valid;
      logic signed [CONV_W-1:0] conv_value;
      logic [COL_W-1:0]         center_col;
      logic [ROW_W-1:0]         center_row;
   } rsp_item_type;

endpackage

[hw/rtl/swc_if.sv]
// handshake channels of the sliding window convolution block
interface swc_req_if import swc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic [PIX_W-1:0]         pixel;
   logic [CIDX_W-1:0]        coef_index;
   logic signed [COEF_W-1:0] coef_value;

   modport source (output valid, cmd, pixel, coef_index, coef_value, input ready);
   modport sink   (input valid, cmd, pixel, coef_index, coef_value, output ready);
endinterface

interface swc_rsp_if import swc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     out_valid;
   logic signed [CONV_W-1:0] conv_value;
   logic [COL_W-1:0]         center_col;
   logic [ROW_W-1:0]         center_row;

   modport source (output valid, out_valid, conv_value, center_col, center_row, input ready);
   modport sink   (input valid, out_valid, conv_value, center_col, center_row, output ready);
endinterface

interface swc_csr_if import swc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/swc_line_buf.sv]
// line store: one word per column holding the previous rows, with same-entry forwarding
module swc_line_buf import swc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  lb_req_type        lb_req,
   output logic [WORD_W-1:0] col_word,
   output logic              clearing
);

   logic [WORD_W-1:0] line_mem [MAX_WIDTH];
   logic [WORD_W-1:0] rd_ff;
   logic              pend_ff;
   logic [COL_W-1:0]  pend_addr_ff;
   logic [PIX_W-1:0]  pend_pix_ff;
   logic              fwd_ff;
   logic [WORD_W-1:0] fwd_word_ff;
   logic              clr_ff;
   logic [COL_W-1:0]  clr_addr_ff;
   logic [WORD_W-1:0] new_word;

   // a write to the same column lands on the edge of the read, so take it from the bypass
   assign col_word = fwd_ff ? fwd_word_ff : rd_ff;
   assign new_word = {col_word[WORD_W-PIX_W-1:0], pend_pix_ff};
   assign clearing = clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= 1'b0;
         fwd_ff      <= 1'b0;
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         pend_ff <= lb_req.en;
         fwd_ff  <= pend_ff && (pend_addr_ff == lb_req.addr);
         if (clr_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == COL_W'(MAX_WIDTH - 1)) begin
               clr_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= lb_req.addr;
      pend_pix_ff  <= lb_req.pixel;
      fwd_word_ff  <= new_word;
   end

   always_ff @(posedge clock) begin
      rd_ff <= line_mem[lb_req.addr];
      if (clr_ff) begin
         line_mem[clr_addr_ff] <= '0;
      end else if (pend_ff) begin
         line_mem[pend_addr_ff] <= new_word;
      end
   end

endmodule

[hw/rtl/swc_rsp_fifo.sv]
// result queue between the arithmetic pipeline and the result channel
module swc_rsp_fifo import swc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   swc_rsp_if.source    rsp_ch
);

   rsp_item_type         entry_mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff;
   logic [RSP_PTR_W-1:0] rd_ptr_ff;
   logic [RSP_CNT_W-1:0] count_ff;
   logic                 pop;

   assign pop               = rsp_ch.valid && rsp_ch.ready;
   assign rsp_ch.valid      = (count_ff != '0);
   assign rsp_ch.out_valid  = entry_mem[rd_ptr_ff].out_valid;
   assign rsp_ch.conv_value = entry_mem[rd_ptr_ff].conv_value;
   assign rsp_ch.center_col = entry_mem[rd_ptr_ff].center_col;
   assign rsp_ch.center_row = entry_mem[rd_ptr_ff].center_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + RSP_CNT_W'(push) - RSP_CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[hw/rtl/sliding_window_convolution.sv]
// streaming 2-d convolution over raster pixels, top level
// latency: a pixel's result passes the input, window, product and row-sum registers, then the result queue
// throughput: one item per clock while req ready is high; the line store reads each clock and writes per pixel
// a coefficient load gives no result
// reset: a pass over all 1024 line store entries zeroes it with req ready low; csr writes still taken
// reset values: 640 x 480 frame, 3 x 3 kernel, all coefficients zero
module sliding_window_convolution import swc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   swc_req_if.sink   req_ch,
   swc_rsp_if.source rsp_ch,
   swc_csr_if.sink   csr_ch
);

   typedef struct packed {
      logic             out_valid;
      logic [COL_W-1:0] center_col;
      logic [ROW_W-1:0] center_row;
   } meta_type;

   function automatic logic [KDIM_W-1:0] half_of(input logic [KDIM_W-1:0] v);
      logic [KDIM_W-1:0] h;
      h = v >> 1;
      if (h > KDIM_W'(HALF_MAX)) begin
         h = KDIM_W'(HALF_MAX);
      end
      return h;
   endfunction

   // configuration
   logic [IMG_W_W-1:0] width_ff;
   logic [ROW_W-1:0]   height_ff;
   logic [KDIM_W-1:0]  kw_ff;
   logic [KDIM_W-1:0]  kh_ff;
   logic [IMG_W_W-1:0] w_eff;
   logic [ROW_W-1:0]   h_eff;
   logic [KDIM_W-1:0]  half_w;
   logic [KDIM_W-1:0]  half_h;
   logic [KDIM_W-1:0]  two_hw;
   logic [KDIM_W-1:0]  two_hh;
   logic [KDIM_W-1:0]  kw_e;

   // position
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [COL_W:0]   cur_col_x;
   logic [ROW_W:0]   cur_row_x;
   logic [COL_W:0]   nxt_col_x;
   logic [ROW_W:0]   nxt_row_x;
   logic [COL_W-1:0] cur_col;
   logic [ROW_W-1:0] cur_row;
   meta_type         meta_in;

   logic req_fire;
   logic pix_fire;
   logic rsp_pop;
   logic clearing;
   logic [RSP_CNT_W-1:0] pend_ff;

   lb_req_type        lb_req;
   logic [WORD_W-1:0] col_word;

   // stage 1
   logic                     s1_vld_ff;
   logic                     s1_cmd_ff;
   logic [PIX_W-1:0]         s1_pix_ff;
   logic [COL_W-1:0]         s1_col_ff;
   logic [CIDX_W-1:0]        s1_cidx_ff;
   logic signed [COEF_W-1:0] s1_cval_ff;
   meta_type                 s1_meta_ff;
   logic [PIX_W-1:0]         colv [MAX_KERNEL];
   logic signed [COEF_W-1:0] sel_in [MAX_KERNEL][MAX_KERNEL];

   logic [PIX_W-1:0]         window_ff [MAX_KERNEL][MAX_KERNEL];
   logic signed [COEF_W-1:0] coef_ff [COEF_SLOTS];

   // stage 2..4
   logic                     s2_vld_ff;
   meta_type                 s2_meta_ff;
   logic signed [COEF_W-1:0] coef_sel_ff [MAX_KERNEL][MAX_KERNEL];
   logic                     s3_vld_ff;
   meta_type                 s3_meta_ff;
   logic signed [PROD_W-1:0] prod_ff [MAX_KERNEL][MAX_KERNEL];
   logic                     s4_vld_ff;
   meta_type                 s4_meta_ff;
   logic signed [RSUM_W-1:0] rsum_in [MAX_KERNEL];
   logic signed [RSUM_W-1:0] rsum_ff [MAX_KERNEL];
   logic signed [TSUM_W-1:0] tsum;
   rsp_item_type             push_item;

   // ---------------------------------------------------------------- config
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_WIDTH_RST;
         height_ff <= IMAGE_HEIGHT_RST;
         kw_ff     <= KERNEL_DIM_RST;
         kh_ff     <= KERNEL_DIM_RST;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_index_type'(csr_ch.index))
            CSR_IMAGE_WIDTH:   width_ff  <= csr_ch.data[IMG_W_W-1:0];
            CSR_IMAGE_HEIGHT:  height_ff <= csr_ch.data[ROW_W-1:0];
            CSR_KERNEL_WIDTH:  kw_ff     <= csr_ch.data[KDIM_W-1:0];
            CSR_KERNEL_HEIGHT: kh_ff     <= csr_ch.data[KDIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_eff = IMG_W_W'(1);
      end else if (width_ff > IMG_W_W'(MAX_WIDTH)) begin
         w_eff = IMG_W_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff == '0) ? ROW_W'(1) : height_ff;
   end

   assign half_w = half_of(kw_ff);
   assign half_h = half_of(kh_ff);
   assign two_hw = KDIM_W'({half_w, 1'b0});
   assign two_hh = KDIM_W'({half_h, 1'b0});
   assign kw_e   = two_hw + 1'b1;

   // -------------------------------------------------------------- position
   // wrap before the pixel covers a size change since the last one
   always_comb begin
      cur_col_x = {1'b0, col_ff};
      cur_row_x = {1'b0, row_ff};
      if (cur_col_x >= w_eff) begin
         cur_col_x = '0;
         cur_row_x = cur_row_x + 1'b1;
      end
      if (cur_row_x >= {1'b0, h_eff}) begin
         cur_row_x = '0;
      end
      cur_col = cur_col_x[COL_W-1:0];
      cur_row = cur_row_x[ROW_W-1:0];

      nxt_col_x = {1'b0, cur_col} + 1'b1;
      nxt_row_x = {1'b0, cur_row};
      if (nxt_col_x >= w_eff) begin
         nxt_col_x = '0;
         nxt_row_x = nxt_row_x + 1'b1;
      end
      if (nxt_row_x >= {1'b0, h_eff}) begin
         nxt_row_x = '0;
      end
   end

   always_comb begin
      meta_in.out_valid  = (cur_col >= COL_W'(two_hw)) && (cur_row >= ROW_W'(two_hh));
      meta_in.center_col = '0;
      meta_in.center_row = '0;
      if ((cur_col >= COL_W'(half_w)) && (cur_row >= ROW_W'(half_h))) begin
         meta_in.center_col = cur_col - COL_W'(half_w);
         meta_in.center_row = cur_row - ROW_W'(half_h);
      end
   end

   // ---------------------------------------------------------------- accept
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign pix_fire     = req_fire && (req_ch.cmd == CMD_PIXEL);
   assign rsp_pop      = rsp_ch.valid && rsp_ch.ready;
   // every pixel in flight has a queue slot held for it
   assign req_ch.ready = !clearing && (pend_ff < RSP_CNT_W'(RSP_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         pend_ff <= '0;
      end else begin
         if (pix_fire) begin
            col_ff <= nxt_col_x[COL_W-1:0];
            row_ff <= nxt_row_x[ROW_W-1:0];
         end
         pend_ff <= pend_ff + RSP_CNT_W'(pix_fire) - RSP_CNT_W'(rsp_pop);
      end
   end

   assign lb_req.en    = pix_fire;
   assign lb_req.addr  = cur_col;
   assign lb_req.pixel = req_ch.pixel;

   swc_line_buf u_line_buf (
      .clock    (clock),
      .reset    (reset),
      .lb_req   (lb_req),
      .col_word (col_word),
      .clearing (clearing)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff  <= req_ch.cmd;
      s1_pix_ff  <= req_ch.pixel;
      s1_col_ff  <= cur_col;
      s1_cidx_ff <= req_ch.coef_index;
      s1_cval_ff <= req_ch.coef_value;
      s1_meta_ff <= meta_in;
   end

   // --------------------------------------------------------------- stage 1
   always_comb begin
      colv[0] = s1_pix_ff;
      for (int k = 1; k < MAX_KERNEL; k++) begin
         colv[k] = col_word[(k-1)*PIX_W +: PIX_W];
      end
   end

   // slot (dy, dx) of the window meets coefficient row 2hh-dy, column 2hw-dx
   always_comb begin
      logic [KDIM_W-1:0] ky;
      logic [KDIM_W-1:0] kx;
      logic [CIDX_W-1:0] ci;
      for (int dy = 0; dy < MAX_KERNEL; dy++) begin
         for (int dx = 0; dx < MAX_KERNEL; dx++) begin
            ky = two_hh - KDIM_W'(dy);
            kx = two_hw - KDIM_W'(dx);
            ci = CIDX_W'(ky) * CIDX_W'(kw_e) + CIDX_W'(kx);
            if ((KDIM_W'(dy) <= two_hh) && (KDIM_W'(dx) <= two_hw)) begin
               sel_in[dy][dx] = coef_ff[ci];
            end else begin
               sel_in[dy][dx] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '{default: '0};
         coef_ff   <= '{default: '0};
      end else if (s1_vld_ff) begin
         if (s1_cmd_ff == CMD_PIXEL) begin
            for (int k = 0; k < MAX_KERNEL; k++) begin
               for (int j = MAX_KERNEL - 1; j >= 1; j--) begin
                  window_ff[k][j] <= window_ff[k][j-1];
               end
               window_ff[k][0] <= colv[k];
            end
         end else if (s1_cidx_ff < CIDX_W'(COEF_SLOTS)) begin
            coef_ff[s1_cidx_ff] <= s1_cval_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff && (s1_cmd_ff == CMD_PIXEL);
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   // coefficients are captured with the window so a following load cannot leak in
   always_ff @(posedge clock) begin
      coef_sel_ff <= sel_in;
      s2_meta_ff  <= s1_meta_ff;
   end

   // --------------------------------------------------------------- stage 2
   always_ff @(posedge clock) begin
      for (int dy = 0; dy < MAX_KERNEL; dy++) begin
         for (int dx = 0; dx < MAX_KERNEL; dx++) begin
            prod_ff[dy][dx] <= $signed({1'b0, window_ff[dy][dx]}) * coef_sel_ff[dy][dx];
         end
      end
      s3_meta_ff <= s2_meta_ff;
   end

   // --------------------------------------------------------------- stage 3
   always_comb begin
      for (int dy = 0; dy < MAX_KERNEL; dy++) begin
         rsum_in[dy] = '0;
         for (int dx = 0; dx < MAX_KERNEL; dx++) begin
            rsum_in[dy] = rsum_in[dy] + RSUM_W'(prod_ff[dy][dx]);
         end
      end
   end

   always_ff @(posedge clock) begin
      rsum_ff    <= rsum_in;
      s4_meta_ff <= s3_meta_ff;
   end

   // --------------------------------------------------------------- stage 4
   // the full window sum stays inside 32 signed bits, no clamp needed
   always_comb begin
      tsum = '0;
      for (int dy = 0; dy < MAX_KERNEL; dy++) begin
         tsum = tsum + TSUM_W'(rsum_ff[dy]);
      end
      push_item.out_valid  = s4_meta_ff.out_valid;
      push_item.conv_value = s4_meta_ff.out_valid ? CONV_W'(tsum) : '0;
      push_item.center_col = s4_meta_ff.center_col;
      push_item.center_row = s4_meta_ff.center_row;
   end

   swc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s4_vld_ff),
      .push_item (push_item),
      .rsp_ch    (rsp_ch)
   );

   // ------------------------------------------------------------ assertions
   a_rsp_has_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> pend_ff != '0)
      else $error("result offered with no pixel pending");

   a_same_col_bypass: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && (s1_cmd_ff == CMD_PIXEL) && $past(s1_vld_ff)
         && ($past(s1_cmd_ff) == CMD_PIXEL) && (s1_col_ff == $past(s1_col_ff)))
      |-> col_word[PIX_W-1:0] == $past(s1_pix_ff))
      else $error("line store bypass lost the previous pixel of this column");

   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.out_valid) |-> rsp_ch.conv_value == '0)
      else $error("border result carries a nonzero sum");

   a_center_inside: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.out_valid)
      |-> (rsp_ch.center_col >= COL_W'(half_w)) && (rsp_ch.center_row >= ROW_W'(half_h)))
      else $error("valid result centered outside the frame margin");

endmodule
